// File: rtl/lsmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_pkg
// Shared constants and types for the streaming linear sieve (Moebius/totient).
// ----------------------------------------------------------------------------
package lsmt_pkg;

    localparam int MAX_VALUE_DEF  = 65536;
    localparam int MAX_PRIMES_DEF = 6542;

    // port field widths
    localparam int NUM_W  = 17;
    localparam int TOT_W  = 16;
    localparam int MU_W   = 2;
    localparam int MERT_W = 10;

    localparam int MERT_CAP    = 256;
    localparam int LIMIT_CAP   = 2**NUM_W - 1;   // largest value the limit register holds
    localparam int LIMIT_RESET = 65536;

    // status from the remainder unit
    typedef struct packed {
        logic done;
        logic divisible;
    } div_stat_t;

endpackage
`default_nettype wire

// File: rtl/linear_sieve_mobius_totient_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_sieve_mobius_totient_top
// Streaming linear sieve: each word crosses off the multiples of the next
// integer by the stored primes, then reports that integer with its primality,
// Moebius value, Euler totient and running Mertens sum.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | dir | word
//  --------+----------------------------------------+-----+---------------------------
//  s_      | s_valid s_ready s_restart              | in  | restart / advance command
//  m_      | m_valid m_ready m_number .. m_beyond   | out | one result per command
//  cfg_    | cfg_valid cfg_ready cfg_upper_limit    | in  | upper limit register
//
//  The work per word grows with the multiples it crosses off; each multiple goes
//  through the single-port number store and, unless the prime exceeds the number,
//  the bit-serial remainder test.
//  After reset the number store is swept clear over all LIM_MAX + 1 entries
//  (65537 by default); a restart sweeps up to the highest address marked so far.
//  s_ready is low while a word is in work or the sweep runs; a result waiting
//  on m_ready holds only the next result, not the next accept.
// ----------------------------------------------------------------------------
module linear_sieve_mobius_totient_top #(
    parameter int MAX_VALUE  = lsmt_pkg::MAX_VALUE_DEF,
    parameter int MAX_PRIMES = lsmt_pkg::MAX_PRIMES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_restart,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic        [lsmt_pkg::NUM_W-1:0]       m_number,
    output logic                                    m_prime_flag,
    output logic signed [lsmt_pkg::MU_W-1:0]        m_mobius,
    output logic        [lsmt_pkg::TOT_W-1:0]       m_totient,
    output logic signed [lsmt_pkg::MERT_W-1:0]      m_mertens,
    output logic                                    m_beyond_limit,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic   [lsmt_pkg::NUM_W-1:0]       cfg_upper_limit
);

    localparam int LIM_MAX = (MAX_VALUE < lsmt_pkg::LIMIT_CAP) ? MAX_VALUE
                                                               : lsmt_pkg::LIMIT_CAP;
    localparam int DEPTH   = LIM_MAX + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int NW      = $clog2(LIM_MAX + 2);
    localparam int MU_W    = lsmt_pkg::MU_W;
    localparam int MERT_W  = lsmt_pkg::MERT_W;
    localparam int ENT_W   = AW + MU_W + 1;
    localparam int PIW     = $clog2(MAX_PRIMES);
    localparam int PCW     = $clog2(MAX_PRIMES + 1);

    localparam logic signed [MERT_W:0] CAP_HI = (MERT_W + 1)'(lsmt_pkg::MERT_CAP);
    localparam logic signed [MERT_W:0] CAP_LO = -CAP_HI;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_LOOK,
        S_FETCH,
        S_PRIME,
        S_PROD,
        S_DIV,
        S_TMUL,
        S_TOT,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic                      pend_reg;
    logic [AW-1:0]             clr_reg;
    logic [AW-1:0]             hwm_reg;
    logic [lsmt_pkg::NUM_W-1:0] ul_reg;
    logic [NW-1:0]             next_reg;
    logic [PCW-1:0]            pc_reg;
    logic [PCW-1:0]            j_reg;
    logic signed [MERT_W-1:0]  mert_reg;
    logic [AW-1:0]             i_reg;
    logic                      over_reg;
    logic                      prime_reg;
    logic signed [MU_W-1:0]    mu_reg;
    logic [AW-1:0]             phi_reg;
    logic [AW-1:0]             p_reg;
    logic [AW-1:0]             m_reg;
    logic                      dvs_reg;

    logic                      m_valid_reg;
    logic [lsmt_pkg::NUM_W-1:0]  m_number_reg;
    logic                      m_prime_flag_reg;
    logic signed [MU_W-1:0]    m_mobius_reg;
    logic [lsmt_pkg::TOT_W-1:0]  m_totient_reg;
    logic signed [MERT_W-1:0]  m_mertens_reg;
    logic                      m_beyond_reg;

    // number store: {crossed off, mu, phi}
    logic [ENT_W-1:0]          num_mem [0:DEPTH-1];
    logic [ENT_W-1:0]          mem_rd_reg;
    logic                      mem_we;
    logic [AW-1:0]             mem_addr;
    logic [ENT_W-1:0]          mem_wdata;

    logic [AW-1:0]             plist_mem [0:MAX_PRIMES-1];
    logic [AW-1:0]             pl_rd_reg;
    logic                      pl_we;

    logic [AW-1:0]             lim;
    logic                      ent_comp;
    logic signed [MU_W-1:0]    ent_mu;
    logic [AW-1:0]             ent_phi;
    logic                      look_prime;
    logic signed [MU_W-1:0]    look_mu;
    logic [AW-1:0]             look_phi;
    logic                      look_append;
    logic signed [MERT_W:0]    mert_sum;
    logic signed [MERT_W-1:0]  mert_next;
    logic signed [MU_W-1:0]    mark_mu;

    logic                      mul_en;
    logic [AW-1:0]             mul_a;
    logic [AW-1:0]             mul_b;
    logic [2*AW-1:0]           prod;
    logic                      prod_over;
    logic                      div_start;
    lsmt_pkg::div_stat_t       div_stat;

    // ---------------------------------------------------------------- datapath
    always_comb begin
        lim = (ul_reg > lsmt_pkg::NUM_W'(LIM_MAX)) ? AW'(LIM_MAX) : AW'(ul_reg);

        ent_comp = mem_rd_reg[ENT_W-1];
        ent_mu   = mem_rd_reg[AW +: MU_W];
        ent_phi  = mem_rd_reg[AW-1:0];

        look_append = 1'b0;
        if (i_reg == AW'(1)) begin
            look_prime = 1'b0;
            look_mu    = 2'sd1;
            look_phi   = AW'(1);
        end else if (!ent_comp) begin
            look_prime  = 1'b1;
            look_mu     = -2'sd1;
            look_phi    = i_reg - AW'(1);
            look_append = (pc_reg < PCW'(MAX_PRIMES));
        end else begin
            look_prime = 1'b0;
            look_mu    = ent_mu;
            look_phi   = ent_phi;
        end

        mert_sum = (MERT_W + 1)'(mert_reg) + (MERT_W + 1)'(look_mu);
        if (mert_sum > CAP_HI) begin
            mert_next = MERT_W'(CAP_HI);
        end else if (mert_sum < CAP_LO) begin
            mert_next = MERT_W'(CAP_LO);
        end else begin
            mert_next = MERT_W'(mert_sum);
        end

        mark_mu   = dvs_reg ? 2'sd0 : -mu_reg;
        prod_over = prod > (2 * AW)'(lim);

        mul_en = ((state_reg == S_PRIME) && (pl_rd_reg >= AW'(2))) || (state_reg == S_TMUL);
        mul_a  = (state_reg == S_TMUL) ? phi_reg : i_reg;
        mul_b  = (state_reg == S_TMUL) ? (dvs_reg ? p_reg : p_reg - AW'(1)) : pl_rd_reg;

        // a prime above i cannot divide i, so skip the remainder test
        div_start = (state_reg == S_PROD) && !prod_over && (p_reg <= i_reg);

        pl_we = (state_reg == S_LOOK) && look_append;

        mem_we    = 1'b0;
        mem_addr  = next_reg[AW-1:0];
        mem_wdata = {1'b1, mark_mu, prod[AW-1:0]};
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = clr_reg;
            mem_wdata = '0;
        end else if (state_reg == S_TOT) begin
            mem_we   = 1'b1;
            mem_addr = m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            num_mem[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= num_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (pl_we) begin
            plist_mem[pc_reg[PIW-1:0]] <= i_reg;
        end
        pl_rd_reg <= plist_mem[j_reg[PIW-1:0]];
    end

    lsmt_mul #(
        .W    (AW)
    ) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    lsmt_div #(
        .W        (AW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (i_reg),
        .divisor  (p_reg),
        .stat     (div_stat)
    );

    // --------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pend_reg    <= 1'b0;
            clr_reg     <= '0;
            hwm_reg     <= AW'(LIM_MAX);
            ul_reg      <= lsmt_pkg::NUM_W'(lsmt_pkg::LIMIT_RESET);
            next_reg    <= NW'(1);
            pc_reg      <= '0;
            j_reg       <= '0;
            mert_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ul_reg <= cfg_upper_limit;
            end
            // S_EMIT decides m_valid_reg on its own
            if (m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == hwm_reg) begin
                        hwm_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= pend_reg ? S_START : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_restart) begin
                            pc_reg    <= '0;
                            mert_reg  <= '0;
                            next_reg  <= NW'(1);
                            clr_reg   <= '0;
                            pend_reg  <= 1'b1;
                            state_reg <= S_CLEAR;
                        end else begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START: begin
                    i_reg <= next_reg[AW-1:0];
                    if (next_reg > NW'(lim)) begin
                        over_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        over_reg  <= 1'b0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    prime_reg <= look_prime;
                    mu_reg    <= look_mu;
                    phi_reg   <= look_phi;
                    mert_reg  <= mert_next;
                    next_reg  <= NW'(i_reg) + NW'(1);
                    if (look_append) begin
                        pc_reg <= pc_reg + PCW'(1);
                    end
                    j_reg     <= '0;
                    state_reg <= S_FETCH;
                end
                S_FETCH: begin
                    state_reg <= (j_reg < pc_reg) ? S_PRIME : S_EMIT;
                end
                S_PRIME: begin
                    p_reg     <= pl_rd_reg;
                    state_reg <= (pl_rd_reg < AW'(2)) ? S_EMIT : S_PROD;
                end
                S_PROD: begin
                    m_reg <= prod[AW-1:0];
                    if (prod_over) begin
                        state_reg <= S_EMIT;
                    end else if (p_reg > i_reg) begin
                        dvs_reg   <= 1'b0;
                        state_reg <= S_TMUL;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        dvs_reg   <= div_stat.divisible;
                        state_reg <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    state_reg <= S_TOT;
                end
                S_TOT: begin
                    if (m_reg > hwm_reg) begin
                        hwm_reg <= m_reg;
                    end
                    if (dvs_reg) begin
                        state_reg <= S_EMIT;
                    end else begin
                        j_reg     <= j_reg + PCW'(1);
                        state_reg <= S_FETCH;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_number_reg     <= over_reg ? '0 : lsmt_pkg::NUM_W'(i_reg);
                        m_prime_flag_reg <= over_reg ? 1'b0 : prime_reg;
                        m_mobius_reg     <= over_reg ? 2'sd0 : mu_reg;
                        m_totient_reg    <= over_reg ? '0 : lsmt_pkg::TOT_W'(phi_reg);
                        m_mertens_reg    <= mert_reg;
                        // next_reg already holds the following number here
                        m_beyond_reg     <= next_reg > NW'(lim);
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_number       = m_number_reg;
    assign m_prime_flag   = m_prime_flag_reg;
    assign m_mobius       = m_mobius_reg;
    assign m_totient      = m_totient_reg;
    assign m_mertens      = m_mertens_reg;
    assign m_beyond_limit = m_beyond_reg;

`ifndef SYNTHESIS
    // one word in work at a time
    a_single_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // marks always land above the number being handled
    a_mark_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TOT) |-> (m_reg > i_reg))
        else $error("multiple written at or below current number");

    // remainder unit reports only while the sequencer waits on it
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("remainder result outside wait state");

    a_prime_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_prime_flag) |->
            (m_mobius == -2'sd1 && m_totient == lsmt_pkg::TOT_W'(m_number - 17'd1)))
        else $error("prime result with inconsistent mu or phi");
`endif

endmodule
`default_nettype wire

// File: rtl/lsmt_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_mul
// Registered W x W multiplier, loaded on enable. Shared by the multiple
// address (i * p) and the totient update (phi * p or phi * (p - 1)).
// ----------------------------------------------------------------------------
module lsmt_mul #(
    parameter int W = 17
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic      [2*W-1:0] prod
);

    logic [2*W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// File: rtl/lsmt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_div
// Bit-serial restoring remainder unit. One quotient bit per cycle;
// reports whether the divisor divides the dividend exactly.
// ----------------------------------------------------------------------------
module lsmt_div #(
    parameter int W = 17
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [W-1:0]      dividend,
    input  wire logic [W-1:0]      divisor,
    output lsmt_pkg::div_stat_t    stat
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  num_reg;
    logic [W-1:0]  dsor_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    trial;
    logic          trial_ge;
    logic [W-1:0]  rem_next;

    always_comb begin
        trial    = {rem_reg, num_reg[W-1]};
        trial_ge = trial >= {1'b0, dsor_reg};
        // remainder stays below the divisor, so it fits W bits
        rem_next = trial_ge ? W'(trial - {1'b0, dsor_reg}) : trial[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            num_reg  <= dividend;
            dsor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[W-2:0], 1'b0};
        end
    end

    assign stat.done      = done_reg;
    assign stat.divisible = (rem_reg == '0);

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: linear sieve (Moebius / totient / Mertens) testbench
// Drives restart/advance words with random gaps and output stalls. A
// scoreboard keeps its own sieve and checks every result word field by
// field. The run switches the upper limit between phases: the extremes, a
// small limit raised without restart, and a long run at the full limit that
// overflows a deliberately short prime table.
// ----------------------------------------------------------------------------

class sieve_board #(int TOP = 65536, int SLOTS = 64);

    typedef struct packed {
        logic [lsmt_pkg::NUM_W-1:0]         number;
        logic                               prime_flag;
        logic signed [lsmt_pkg::MU_W-1:0]   mobius;
        logic [lsmt_pkg::TOT_W-1:0]         totient;
        logic signed [lsmt_pkg::MERT_W-1:0] mertens;
        logic                               beyond;
    } report_t;

    report_t     expected_reports[$];
    int unsigned upper_limit;
    int          mismatch_count;
    int          reports_checked;
    int          primes_seen;
    int          beyond_seen;

    bit          crossed [0:TOP];
    int          mu_at   [0:TOP];
    int unsigned phi_at  [0:TOP];
    int unsigned primes  [SLOTS];
    int unsigned prime_count;
    int unsigned next_num;
    int          mertens_sum;

    function new();
        upper_limit = lsmt_pkg::LIMIT_RESET;
        clear_sieve();
    endfunction

    function void clear_sieve();
        foreach (crossed[k]) crossed[k] = 1'b0;
        prime_count = 0;
        next_num    = 1;
        mertens_sum = 0;
    endfunction

    // one accepted command word -> one expected result word
    function void note_command(bit restart);
        report_t           r;
        int unsigned       lim;
        int unsigned       n;
        int unsigned       p;
        int unsigned       m;
        int unsigned       phi;
        longint unsigned   prod;
        int                mu;
        bit                is_p;

        if (restart) clear_sieve();
        lim = (upper_limit < TOP) ? upper_limit : TOP;
        n   = next_num;
        r   = '0;

        if (n > lim) begin
            r.mertens = mertens_sum[lsmt_pkg::MERT_W-1:0];
            r.beyond  = 1'b1;
            expected_reports.push_back(r);
            return;
        end

        is_p = 1'b0;
        if (n == 1) begin
            mu_at[1]  = 1;
            phi_at[1] = 1;
        end else if (!crossed[n]) begin
            is_p      = 1'b1;
            mu_at[n]  = -1;
            phi_at[n] = n - 1;
            // a full table still reports the prime, it just never marks with it
            if (prime_count < SLOTS) begin
                primes[prime_count] = n;
                prime_count++;
            end
        end
        mu  = mu_at[n];
        phi = phi_at[n];

        for (int j = 0; j < prime_count; j++) begin
            p    = primes[j];
            prod = longint'(n) * p;
            if (prod > lim) break;
            m          = prod[31:0];
            crossed[m] = 1'b1;
            if (n % p == 0) begin
                mu_at[m]  = 0;
                phi_at[m] = phi * p;
                break;
            end
            mu_at[m]  = -mu;
            phi_at[m] = phi * (p - 1);
        end

        mertens_sum += mu;
        if (mertens_sum > lsmt_pkg::MERT_CAP)  mertens_sum = lsmt_pkg::MERT_CAP;
        if (mertens_sum < -lsmt_pkg::MERT_CAP) mertens_sum = -lsmt_pkg::MERT_CAP;
        next_num = n + 1;

        r.number     = n[lsmt_pkg::NUM_W-1:0];
        r.prime_flag = is_p;
        r.mobius     = mu[lsmt_pkg::MU_W-1:0];
        r.totient    = phi[lsmt_pkg::TOT_W-1:0];
        r.mertens    = mertens_sum[lsmt_pkg::MERT_W-1:0];
        r.beyond     = (next_num > lim);
        expected_reports.push_back(r);
    endfunction

    task report_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH: %s", what);
    endtask

    task field_check(string name, int unsigned num,
                     logic signed [31:0] got, logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("number %0d: %s is %0d, expected %0d",
                                      num, name, got, want));
    endtask

    task check_report(logic [lsmt_pkg::NUM_W-1:0]         number,
                      logic                               prime_flag,
                      logic signed [lsmt_pkg::MU_W-1:0]   mobius,
                      logic [lsmt_pkg::TOT_W-1:0]         totient,
                      logic signed [lsmt_pkg::MERT_W-1:0] mertens,
                      logic                               beyond);
        report_t want;
        if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("result word with no command pending, number %0d",
                                      number));
            return;
        end
        want = expected_reports.pop_front();
        reports_checked++;
        if (want.prime_flag) primes_seen++;
        if (want.beyond)     beyond_seen++;
        field_check("number",       want.number, number,     want.number);
        field_check("prime_flag",   want.number, prime_flag, want.prime_flag);
        field_check("mobius",       want.number, mobius,     want.mobius);
        field_check("totient",      want.number, totient,    want.totient);
        field_check("mertens",      want.number, mertens,    want.mertens);
        field_check("beyond_limit", want.number, beyond,     want.beyond);
    endtask

endclass

module tb_top;

    localparam int SIEVE_TOP   = 65536;
    // short prime table so the full-table case shows up within the run
    localparam int PRIME_SLOTS = 64;

    localparam int SETTLE_CYCLES  = (lsmt_pkg::NUM_W + 8) * PRIME_SLOTS + 32;
    localparam int CYCLE_LIMIT    = 8000000;
    localparam int TOTAL_COMMANDS = 700;
    localparam int QUIET_TAIL     = 80;
    localparam int LONG_RUN       = 360;

    logic                                   aclk;
    logic                                   aresetn;
    logic                                   s_valid;
    logic                                   s_ready;
    logic                                   s_restart;
    logic                                   m_valid;
    logic                                   m_ready;
    logic        [lsmt_pkg::NUM_W-1:0]      m_number;
    logic                                   m_prime_flag;
    logic signed [lsmt_pkg::MU_W-1:0]       m_mobius;
    logic        [lsmt_pkg::TOT_W-1:0]      m_totient;
    logic signed [lsmt_pkg::MERT_W-1:0]     m_mertens;
    logic                                   m_beyond_limit;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic        [lsmt_pkg::NUM_W-1:0]      cfg_upper_limit;

    sieve_board #(SIEVE_TOP, PRIME_SLOTS) board;

    bit gaps_on;
    int cycle_count;
    int commands_sent;
    int restarts_sent;
    int limit_writes;

    linear_sieve_mobius_totient_top #(
        .MAX_VALUE  (SIEVE_TOP),
        .MAX_PRIMES (PRIME_SLOTS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_number        (m_number),
        .m_prime_flag    (m_prime_flag),
        .m_mobius        (m_mobius),
        .m_totient       (m_totient),
        .m_mertens       (m_mertens),
        .m_beyond_limit  (m_beyond_limit),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_upper_limit (cfg_upper_limit)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, board.expected_reports.size());
            $display("Mismatches found");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            board.check_report(m_number, m_prime_flag, m_mobius, m_totient,
                               m_mertens, m_beyond_limit);
        end
    end

    // result side back-pressure in bursts of random length, only while gaps are on
    initial begin : ready_driver
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_command(input bit restart);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        board.note_command(restart);
        commands_sent++;
        if (restart) restarts_sent++;
    endtask

    task automatic stop_commands();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // limit changes only with the block drained and its marking pass over
    task automatic write_limit(input int unsigned value);
        stop_commands();
        while (board.expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_upper_limit <= value[lsmt_pkg::NUM_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        board.upper_limit = value;
        limit_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned lim_pick;
        int          pick;
        int          run_len;
        bit          big;
        bit          restart;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_restart       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_upper_limit = '0;
        gaps_on         = 1'b1;
        board           = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limit: 1 through 9 covers one, primes, squares, mu = +1, then restart
        repeat (9) send_command(1'b0);
        send_command(1'b1);

        // smallest limit: number one is already the last
        write_limit(1);
        send_command(1'b1);
        send_command(1'b0);

        // run past a small limit, then raise it without restart:
        // 6, 8, 9 and 10 were never crossed off and come out as primes
        write_limit(5);
        send_command(1'b1);
        repeat (5) send_command(1'b0);
        write_limit(12);
        repeat (5) send_command(1'b0);

        // full limit, long enough to fill the prime table
        write_limit(SIEVE_TOP);
        send_command(1'b1);
        repeat (LONG_RUN) send_command(1'b0);

        while (commands_sent < TOTAL_COMMANDS) begin
            pick = $urandom_range(0, 9);
            big  = 1'b0;
            case (pick)
                0: lim_pick = 1;
                1: begin
                    lim_pick = SIEVE_TOP;
                    big      = 1'b1;
                end
                2: begin
                    lim_pick = SIEVE_TOP - 1;
                    big      = 1'b1;
                end
                3: lim_pick = $urandom_range(2, 40);
                default: lim_pick = $urandom_range(41, 2500);
            endcase
            write_limit(lim_pick);
            // big limits restart so the marked range (and the next clear) stays short
            run_len = big ? $urandom_range(20, 60) : $urandom_range(30, 90);
            for (int k = 0; k < run_len; k++) begin
                if (commands_sent >= TOTAL_COMMANDS - QUIET_TAIL) gaps_on = 1'b0;
                if (k == 0) restart = big || ($urandom_range(0, 1) == 1);
                else        restart = ($urandom_range(0, 39) == 0);
                send_command(restart);
            end
        end

        stop_commands();
        while (board.expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d command words (%0d restarts) over %0d limit settings, 1 to %0d.",
                 commands_sent, restarts_sent, limit_writes + 1, SIEVE_TOP);
        $display("Checked %0d result words: %0d primes, %0d past the limit; prime table %0d.",
                 board.reports_checked, board.primes_seen, board.beyond_seen, PRIME_SLOTS);
        if (board.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: linear_sieve_mobius_totient_top.f
rtl/lsmt_pkg.sv
rtl/lsmt_mul.sv
rtl/lsmt_div.sv
rtl/linear_sieve_mobius_totient_top.sv
sim/tb_top.sv
